>>> sv/lpsl_pkg.sv
// Package for the longest palindromic subsequence length block.
// Holds sizes, transaction payload types and the cell result type.
// No dependencies.
`default_nettype none

package lpsl_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int SCORE_W = 7;
    localparam int SYM_W   = 8;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int TBL_DEPTH = MAX_LEN * MAX_LEN;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] lps_length;
        logic               truncated;
    } t_out_item;

    typedef struct packed {
        logic               match;
        logic [SCORE_W-1:0] best;
        logic [SCORE_W-1:0] bumped;
    } t_cell_res;

endpackage

`default_nettype wire

>>> sv/lpsl_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing; used for the text buffer and the span table.
`default_nettype none

module lpsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

>>> sv/lpsl_cell_unit.sv
// Shared cell unit: byte compare, max of the two shorter spans, inner plus two.
// Depends on lpsl_pkg.
`default_nettype none

module lpsl_cell_unit
    import lpsl_pkg::*;
(
    input  wire logic [SYM_W-1:0]   i_sym_lo,
    input  wire logic [SYM_W-1:0]   i_sym_hi,
    input  wire logic [SCORE_W-1:0] i_score_a,
    input  wire logic [SCORE_W-1:0] i_score_b,
    output t_cell_res               o_res
);

    always_comb begin
        o_res.match  = (i_sym_lo == i_sym_hi);
        o_res.best   = (i_score_a < i_score_b) ? i_score_b : i_score_a;
        o_res.bumped = i_score_a + SCORE_W'(2);
    end

endmodule

`default_nettype wire

>>> sv/longest_palindromic_subsequence_length.sv
// Top level of the longest palindromic subsequence length block.
// Depends on lpsl_pkg, lpsl_ram and lpsl_cell_unit.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one byte per
// transaction, one per cycle, with last marking the final byte. Up to
// MAX_LEN bytes are stored; further bytes are dropped and set truncated.
// After the last byte the block stops taking input and fills the span
// table with a single compare/max/add unit through the table RAM ports:
//   first the main diagonal, one entry per stored byte,
//   then a read step and an evaluate step for each longer span,
//   and an extra inner read and evaluate step for each span longer
//   than two bytes whose end bytes match.
// The result sits in an output register (o_out_valid / i_out_ready /
// o_out_data). The next string loads while it waits; a second finished
// result holds until the first is taken.
// Reset (synchronous, active low) empties the string and drops any pending
// result. Stored bytes and table entries need no clearing.
`default_nettype none

module longest_palindromic_subsequence_length
    import lpsl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_item i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_EVAL    = 3'd3;
    localparam logic [2:0] ST_READ_IN = 3'd4;
    localparam logic [2:0] ST_EVAL_IN = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_trunc, n_trunc;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_span, n_span;
    logic [SCORE_W-1:0] r_result, n_result;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_acc;
    logic               room;
    logic [IDX_W-1:0]   hi;
    logic               row_end;
    logic               txt_we;
    logic [IDX_W-1:0]   txt_waddr;
    logic [SYM_W-1:0]   sym_lo, sym_hi;
    logic               tbl_we;
    logic [ADDR_W-1:0]  tbl_waddr, tbl_raddr_a, tbl_raddr_b;
    logic [SCORE_W-1:0] tbl_wdata, score_a, score_b;
    logic               cell_wr;
    t_cell_res          unit_res;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign room        = (r_count < CNT_W'(MAX_LEN));
    assign hi          = IDX_W'(CNT_W'(r_lo) + r_span - CNT_W'(1));
    assign row_end     = ({1'b0, hi} == (r_n - CNT_W'(1)));
    assign txt_we      = in_acc && room;
    assign txt_waddr   = r_count[IDX_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lpsl_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_text (
        .i_clk     (i_clk),
        .i_we      (txt_we),
        .i_waddr   (txt_waddr),
        .i_wdata   (i_in_data.symbol),
        .i_raddr_a (r_lo),
        .i_raddr_b (hi),
        .o_rdata_a (sym_lo),
        .o_rdata_b (sym_hi)
    );

    lpsl_ram #(.WIDTH(SCORE_W), .DEPTH(TBL_DEPTH)) u_span (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (tbl_waddr),
        .i_wdata   (tbl_wdata),
        .i_raddr_a (tbl_raddr_a),
        .i_raddr_b (tbl_raddr_b),
        .o_rdata_a (score_a),
        .o_rdata_b (score_b)
    );

    lpsl_cell_unit u_cell (
        .i_sym_lo  (sym_lo),
        .i_sym_hi  (sym_hi),
        .i_score_a (score_a),
        .i_score_b (score_b),
        .o_res     (unit_res)
    );

    always_comb begin
        tbl_raddr_a = {IDX_W'(r_lo + IDX_W'(1)), hi};
        tbl_raddr_b = {r_lo, IDX_W'(hi - IDX_W'(1))};
        if (r_state == ST_READ_IN) begin
            tbl_raddr_a = {IDX_W'(r_lo + IDX_W'(1)), IDX_W'(hi - IDX_W'(1))};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_trunc     = r_trunc;
        n_lo        = r_lo;
        n_span      = r_span;
        n_result    = r_result;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        tbl_we      = 1'b0;
        tbl_waddr   = {r_lo, hi};
        tbl_wdata   = unit_res.best;
        cell_wr     = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_n     = room ? r_count + CNT_W'(1) : r_count;
                        n_trunc = r_ovf || !room;
                        n_lo    = '0;
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                tbl_we    = 1'b1;
                tbl_waddr = {r_lo, r_lo};
                tbl_wdata = SCORE_W'(1);
                if ({1'b0, r_lo} == r_n - CNT_W'(1)) begin
                    n_lo = '0;
                    if (r_n == CNT_W'(1)) begin
                        n_result = SCORE_W'(1);
                        n_state  = ST_DONE;
                    end else begin
                        n_span  = CNT_W'(2);
                        n_state = ST_READ;
                    end
                end else begin
                    n_lo = r_lo + IDX_W'(1);
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!unit_res.match) begin
                    tbl_wdata = unit_res.best;
                    cell_wr   = 1'b1;
                end else if (r_span == CNT_W'(2)) begin
                    tbl_wdata = SCORE_W'(2);
                    cell_wr   = 1'b1;
                end else begin
                    n_state = ST_READ_IN;
                end
            end
            ST_READ_IN: begin
                n_state = ST_EVAL_IN;
            end
            ST_EVAL_IN: begin
                tbl_wdata = unit_res.bumped;
                cell_wr   = 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.lps_length = r_result;
                    n_out.truncated  = r_trunc;
                    n_out_valid      = 1'b1;
                    n_count          = '0;
                    n_ovf            = 1'b0;
                    n_state          = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (cell_wr) begin
            tbl_we   = 1'b1;
            n_result = tbl_wdata;
            if (row_end) begin
                n_lo = '0;
                if (r_span == r_n) begin
                    n_state = ST_DONE;
                end else begin
                    n_span  = r_span + CNT_W'(1);
                    n_state = ST_READ;
                end
            end else begin
                n_lo    = r_lo + IDX_W'(1);
                n_state = ST_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_trunc  <= n_trunc;
        r_lo     <= n_lo;
        r_span   <= n_span;
        r_result <= n_result;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

>>> sv/lpsl_checker.sv
// Port checker for the longest palindromic subsequence length block.
// Depends on lpsl_pkg; bound to the top level at the end of this file.
`default_nettype none

module lpsl_checker
    import lpsl_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction dropped or changed while stalled");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.lps_length != '0) &&
                        (o_out_data.lps_length <= SCORE_W'(MAX_LEN)))
        else $error("result length out of range");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("input still taken after final byte");

    a_byte_keeps_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.last |=> o_in_ready)
        else $error("input stalled in the middle of a string");

endmodule

bind longest_palindromic_subsequence_length lpsl_checker u_lpsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
